>>> rtl/pep_pkg.sv
// Shared types, constants and CORDIC helpers for the point projection block.
// Used by point_equirect_projection; depends on nothing else.

package pep_pkg;

	// Default widths for the top-level parameters
	localparam int COORD_BITS_DEF = 18;
	localparam int ANGLE_BITS_DEF = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 48;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROT_ROW0     = 4'd0,
		CFG_ROT_ROW1     = 4'd1,
		CFG_ROT_ROW2     = 4'd2,
		CFG_SHIFT_X      = 4'd3,
		CFG_SHIFT_Y      = 4'd4,
		CFG_SHIFT_Z      = 4'd5,
		CFG_IMAGE_WIDTH  = 4'd6,
		CFG_IMAGE_HEIGHT = 4'd7
	} cfg_reg_t;

	// Register reset values
	localparam logic [47:0] ROW0_RESET    = 48'd16384;
	localparam logic [47:0] ROW1_RESET    = 48'd211106232532992;
	localparam logic [47:0] ROW2_RESET    = 48'd1073741824;
	localparam logic [17:0] SHIFT_X_RESET = 18'd0;
	localparam logic [17:0] SHIFT_Y_RESET = 18'd1330;
	localparam logic [17:0] SHIFT_Z_RESET = 18'd170;
	localparam logic [12:0] WIDTH_RESET   = 13'd1920;
	localparam logic [12:0] HEIGHT_RESET  = 13'd920;
	localparam logic [12:0] SIZE_MAX      = 13'd4096;

	// Drop threshold on squared distance (mm^2), and the side below which it applies
	localparam logic [9:0] DROP_DIST2 = 10'd100;
	localparam int         NEAR_LIMIT = 10;

	// Normalization: largest magnitude lands in [2^28, 2^29)
	localparam int NORM_MSB = 28;
	localparam int NORM_W   = 29;

	// Integer square root over a 60-bit operand, one result bit per step
	localparam int ROOT_STEPS = 30;
	localparam int RT_W       = 60;

	// CORDIC vectoring, angles in 2^-32 turn
	localparam int CORDIC_STEPS = 28;
	localparam int CORDIC_W     = 34;
	localparam logic signed [CORDIC_W-1:0] HALF_TURN = CORDIC_W'(64'sh80000000);

	typedef struct packed {
		logic                        zero;
		logic signed [CORDIC_W-1:0]  x;
		logic signed [CORDIC_W-1:0]  y;
		logic signed [CORDIC_W-1:0]  a;
	} cordic_t;

	// Elementary rotation angles atan(2^-k) in 2^-32 turn
	function automatic logic signed [CORDIC_W-1:0] turn_step(input int k);
		logic [31:0] t;
		case (k)
			0:  t = 32'h20000000;
			1:  t = 32'h12E4051E;
			2:  t = 32'h09FB385B;
			3:  t = 32'h051111D4;
			4:  t = 32'h028B0D43;
			5:  t = 32'h0145D7E1;
			6:  t = 32'h00A2F61E;
			7:  t = 32'h00517C55;
			8:  t = 32'h0028BE53;
			9:  t = 32'h00145F2F;
			10: t = 32'h000A2F98;
			11: t = 32'h000517CC;
			12: t = 32'h00028BE6;
			13: t = 32'h000145F3;
			14: t = 32'h0000A2FA;
			15: t = 32'h0000517D;
			16: t = 32'h000028BE;
			17: t = 32'h0000145F;
			18: t = 32'h00000A30;
			19: t = 32'h00000518;
			20: t = 32'h0000028C;
			21: t = 32'h00000146;
			22: t = 32'h000000A3;
			23: t = 32'h00000051;
			24: t = 32'h00000029;
			25: t = 32'h00000014;
			26: t = 32'h0000000A;
			27: t = 32'h00000005;
			default: t = 32'h0;
		endcase
		return $signed(CORDIC_W'(t));
	endfunction

	// Fold the left half plane onto the right one, flag the null vector
	function automatic cordic_t cordic_pre(input logic signed [CORDIC_W-1:0] x,
			input logic signed [CORDIC_W-1:0] y);
		cordic_t r;
		r.zero = (x == '0) && (y == '0);
		r.x    = x;
		r.y    = y;
		r.a    = '0;
		if (x[CORDIC_W-1]) begin
			r.a = y[CORDIC_W-1] ? -HALF_TURN : HALF_TURN;
			r.x = -x;
			r.y = -y;
		end
		return r;
	endfunction

	// One vectoring step: rotate toward y = 0, accumulate the angle
	function automatic cordic_t cordic_step(input cordic_t c, input int k);
		cordic_t r;
		logic signed [CORDIC_W-1:0] dx;
		logic signed [CORDIC_W-1:0] dy;
		r  = c;
		dx = $signed(c.y) >>> k;
		dy = $signed(c.x) >>> k;
		if (!c.y[CORDIC_W-1] && (c.y != '0)) begin
			r.x = c.x + dx;
			r.y = c.y - dy;
			r.a = c.a + turn_step(k);
		end else begin
			r.x = c.x - dx;
			r.y = c.y + dy;
			r.a = c.a - turn_step(k);
		end
		return r;
	endfunction

endpackage

>>> rtl/point_equirect_projection.sv
// Top level of the lidar point to equirectangular pixel projection pipeline.
// Depends on pep_pkg for constants, the CORDIC step functions and types.

// Takes one point per clock while s_tready is high and returns one result per
// point, in order. The point passes 71 register stages on its way to the
// output. The stages are: seven front stages (capture, products, rotate and
// translate, drop test, leading-one search, normalizing shift, squares), the
// square-root chain (one load stage and 30 steps) that carries the 28-step yaw
// CORDIC beside it, the pitch CORDIC (one fold stage and 28 steps), three
// pixel-mapping stages and the output register. A two-entry output buffer keeps
// the pipeline moving while a result waits, and s_tready is driven from a register,
// so a stalled consumer holds the input back once the skid fills. Configuration writes
// are taken at once and must only be issued while no point is in flight.

module point_equirect_projection
	import pep_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int ANGLE_BITS = ANGLE_BITS_DEF,
	localparam int IN_W  = ((3 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((24 + 3 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_W-1:0]       s_tdata,   // in_x, in_y, in_z, zero pad
	input  logic                  s_tlast,   // frame_end
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata,   // pixel_col, pixel_row, out_x, out_y, out_z, zero pad
	output logic                  m_tuser,   // kept
	output logic                  m_tlast    // frame_end_out
);

	localparam int CB     = COORD_BITS;
	localparam int PROD_W = CB + 16;
	localparam int SUM_W  = CB + 18;
	localparam int RND_W  = CB + 4;
	localparam int C_W    = ((RND_W > 18) ? RND_W : 18) + 1;
	localparam int MSB_W  = $clog2(C_W);
	localparam int SH_W   = C_W + NORM_MSB;
	localparam int PT_W   = 3 * CB + 2;          // kept, last, z, y, x
	localparam int ANG_W  = ANGLE_BITS + 2;
	localparam int FR_W   = ANGLE_BITS + 1;
	localparam int PM_W   = FR_W + 13;
	localparam int OB_W   = OUT_W + 2;           // kept, last, tdata

	localparam logic signed [SUM_W-1:0]   RND_ADD = SUM_W'(8192);
	localparam logic signed [CORDIC_W-1:0] A_RND  = CORDIC_W'(1) <<< (31 - ANGLE_BITS);
	localparam logic signed [ANG_W:0]     HALF_U  = (ANG_W + 1)'(1) <<< (ANGLE_BITS - 1);
	localparam logic signed [ANG_W:0]     FULL_U  = (ANG_W + 1)'(1) <<< ANGLE_BITS;
	localparam logic signed [ANG_W+1:0]   HALF_V  = (ANG_W + 2)'(1) <<< (ANGLE_BITS - 1);
	localparam logic signed [ANG_W+1:0]   FULL_V  = (ANG_W + 2)'(1) <<< ANGLE_BITS;

	// Round a 2^-32 turn angle half up to ANGLE_BITS; null vectors give zero
	function automatic logic signed [ANG_W-1:0] angle_round(
			input logic signed [CORDIC_W-1:0] a, input logic zero);
		logic signed [CORDIC_W-1:0] t;
		t = a + A_RND;
		return zero ? '0 : ANG_W'(t >>> (32 - ANGLE_BITS));
	endfunction

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	logic [47:0]              rot_q   [3];
	logic signed [17:0]       shift_q [3];
	logic [12:0]              width_q;
	logic [12:0]              height_q;

	assign cfg_ready = 1'b1;

	// Write a register on each request; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0]   <= ROW0_RESET;
			rot_q[1]   <= ROW1_RESET;
			rot_q[2]   <= ROW2_RESET;
			shift_q[0] <= SHIFT_X_RESET;
			shift_q[1] <= SHIFT_Y_RESET;
			shift_q[2] <= SHIFT_Z_RESET;
			width_q    <= WIDTH_RESET;
			height_q   <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				CFG_ROT_ROW0:     rot_q[0]   <= cfg_data;
				CFG_ROT_ROW1:     rot_q[1]   <= cfg_data;
				CFG_ROT_ROW2:     rot_q[2]   <= cfg_data;
				CFG_SHIFT_X:      shift_q[0] <= cfg_data[17:0];
				CFG_SHIFT_Y:      shift_q[1] <= cfg_data[17:0];
				CFG_SHIFT_Z:      shift_q[2] <= cfg_data[17:0];
				CFG_IMAGE_WIDTH:  width_q    <= cfg_data[12:0];
				CFG_IMAGE_HEIGHT: height_q   <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// Effective image size: zero acts as one, large values cap at 4096
	logic [12:0] w_eff;
	logic [12:0] h_eff;

	always_comb begin
		w_eff = (width_q == '0) ? 13'd1 : ((width_q > SIZE_MAX) ? SIZE_MAX : width_q);
		h_eff = (height_q == '0) ? 13'd1 : ((height_q > SIZE_MAX) ? SIZE_MAX : height_q);
	end

	// ---------------------------------------------------------------------
	// Flow control
	// ---------------------------------------------------------------------
	logic adv;
	logic skid_v_q;

	assign adv      = !skid_v_q;
	assign s_tready = adv;

	// ---------------------------------------------------------------------
	// Stage 1: capture the point
	// ---------------------------------------------------------------------
	logic                 v_s1;
	logic signed [CB-1:0] pnt_s1 [3];
	logic [PT_W-1:0]      pt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pnt_s1[0] <= s_tdata[CB-1:0];
			pnt_s1[1] <= s_tdata[2*CB-1:CB];
			pnt_s1[2] <= s_tdata[3*CB-1:2*CB];
			pt_s1     <= {1'b0, s_tlast, s_tdata[3*CB-1:0]};
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: nine rotation products
	// ---------------------------------------------------------------------
	logic                     v_s2;
	logic signed [PROD_W-1:0] prod_s2 [3][3];
	logic [PT_W-1:0]          pt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s2[i][j] <= PROD_W'($signed(rot_q[i][16*j +: 16])) *
						PROD_W'(pnt_s1[j]);
				end
			end
			pt_s2 <= pt_s1;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: sum, round half up to millimetres, translate
	// ---------------------------------------------------------------------
	logic                    v_s3;
	logic signed [C_W-1:0]   c_s3 [3];
	logic [PT_W-1:0]         pt_s3;
	logic signed [SUM_W-1:0] dot  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dot[i] = SUM_W'(prod_s2[i][0]) + SUM_W'(prod_s2[i][1]) +
				SUM_W'(prod_s2[i][2]) + RND_ADD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				c_s3[i] <= C_W'($signed(dot[i][SUM_W-1:14])) + C_W'(shift_q[i]);
			end
			pt_s3 <= pt_s2;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 4: drop test, magnitudes and their maximum
	// ---------------------------------------------------------------------
	logic             v_s4;
	logic [C_W-1:0]   mag_s4 [3];
	logic [C_W-1:0]   max_s4;
	logic [2:0]       neg_s4;
	logic [PT_W-1:0]  pt_s4;
	logic [C_W-1:0]   mag  [3];
	logic [C_W-1:0]   mmax;
	logic             near;
	logic [9:0]       dist2;
	logic             kept;

	always_comb begin
		near  = 1'b1;
		dist2 = '0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = c_s3[i][C_W-1] ? C_W'(-c_s3[i]) : C_W'(c_s3[i]);
			if (mag[i] >= C_W'(NEAR_LIMIT)) near = 1'b0;
			dist2 = dist2 + 10'(mag[i][3:0]) * 10'(mag[i][3:0]);
		end
		kept = !near || (dist2 >= DROP_DIST2);
		mmax = (mag[0] > mag[1]) ? mag[0] : mag[1];
		mmax = (mag[2] > mmax) ? mag[2] : mmax;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s4 <= mag;
			max_s4 <= mmax;
			neg_s4 <= {c_s3[2][C_W-1], c_s3[1][C_W-1], c_s3[0][C_W-1]};
			pt_s4  <= {kept, pt_s3[PT_W-2:0]};
		end
	end

	// ---------------------------------------------------------------------
	// Stage 5: leading-one position of the maximum
	// ---------------------------------------------------------------------
	logic             v_s5;
	logic [C_W-1:0]   mag_s5 [3];
	logic [MSB_W-1:0] lead_s5;
	logic [2:0]       neg_s5;
	logic [PT_W-1:0]  pt_s5;
	logic [MSB_W-1:0] lead;

	always_comb begin
		lead = '0;
		for (int i = 0; i < C_W; i++) begin
			if (max_s4[i]) lead = MSB_W'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s5  <= mag_s4;
			lead_s5 <= lead;
			neg_s5  <= neg_s4;
			pt_s5   <= pt_s4;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 6: scale all three so the largest sits at bit 28
	// ---------------------------------------------------------------------
	logic              v_s6;
	logic [NORM_W-1:0] nm_s6 [3];
	logic [2:0]        neg_s6;
	logic [PT_W-1:0]   pt_s6;
	logic [SH_W-1:0]   scaled [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			scaled[i] = ({mag_s5[i], NORM_MSB'(0)}) >> lead_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) nm_s6[i] <= scaled[i][NORM_W-1:0];
			neg_s6 <= neg_s5;
			pt_s6  <= pt_s5;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 7: restore signs, square x and z
	// ---------------------------------------------------------------------
	logic                     v_s7;
	logic signed [NORM_W:0]   n_s7 [3];
	logic [2*NORM_W-1:0]      sqx_s7;
	logic [2*NORM_W-1:0]      sqz_s7;
	logic [PT_W-1:0]          pt_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (adv) v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				n_s7[i] <= neg_s6[i] ? -$signed({1'b0, nm_s6[i]}) : $signed({1'b0, nm_s6[i]});
			end
			sqx_s7 <= nm_s6[0] * nm_s6[0];
			sqz_s7 <= nm_s6[2] * nm_s6[2];
			pt_s7  <= pt_s6;
		end
	end

	// ---------------------------------------------------------------------
	// Square-root chain with the yaw CORDIC alongside.
	// Index 0 is loaded from stage 7; each step advances one index.
	// ---------------------------------------------------------------------
	logic                   rv_s       [ROOT_STEPS+1];
	logic [RT_W-1:0]        root_rem_s [ROOT_STEPS+1];
	logic [RT_W-1:0]        root_res_s [ROOT_STEPS+1];
	cordic_t                yaw_s      [ROOT_STEPS+1];
	logic signed [NORM_W:0] ny_s       [ROOT_STEPS+1];
	logic [PT_W-1:0]        rpt_s      [ROOT_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rv_s[0] <= 1'b0;
		else if (adv) rv_s[0] <= v_s7;
	end

	// Load the root operand and fold the yaw vector (x from z, y from x)
	always_ff @(posedge clk) begin
		if (adv) begin
			root_rem_s[0] <= RT_W'(sqx_s7) + RT_W'(sqz_s7);
			root_res_s[0] <= '0;
			yaw_s[0]      <= cordic_pre(CORDIC_W'(n_s7[2]), CORDIC_W'(n_s7[0]));
			ny_s[0]       <= n_s7[1];
			rpt_s[0]      <= pt_s7;
		end
	end

	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
		localparam logic [RT_W-1:0] BIT = RT_W'(1) << (2 * (ROOT_STEPS - 1 - k));
		logic [RT_W-1:0] trial;
		logic            take;

		assign trial = root_res_s[k] + BIT;
		assign take  = root_rem_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rv_s[k+1] <= 1'b0;
			else if (adv) rv_s[k+1] <= rv_s[k];
		end

		// Settle one result bit; step the yaw vector while steps remain
		always_ff @(posedge clk) begin
			if (adv) begin
				root_rem_s[k+1] <= take ? (root_rem_s[k] - trial) : root_rem_s[k];
				root_res_s[k+1] <= take ? ((root_res_s[k] >> 1) + BIT) : (root_res_s[k] >> 1);
				yaw_s[k+1]      <= (k < CORDIC_STEPS) ? cordic_step(yaw_s[k], k) : yaw_s[k];
				ny_s[k+1]       <= ny_s[k];
				rpt_s[k+1]      <= rpt_s[k];
			end
		end
	end

	// ---------------------------------------------------------------------
	// Pitch CORDIC chain: index 0 folds (hypot, -y), then one step per index
	// ---------------------------------------------------------------------
	logic                    pv_s    [CORDIC_STEPS+1];
	cordic_t                 pitch_s [CORDIC_STEPS+1];
	logic signed [ANG_W-1:0] yawr_s  [CORDIC_STEPS+1];
	logic [PT_W-1:0]         ppt_s   [CORDIC_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pv_s[0] <= 1'b0;
		else if (adv) pv_s[0] <= rv_s[ROOT_STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pitch_s[0] <= cordic_pre($signed(CORDIC_W'(root_res_s[ROOT_STEPS])),
				-CORDIC_W'(ny_s[ROOT_STEPS]));
			yawr_s[0]  <= angle_round(yaw_s[ROOT_STEPS].a, yaw_s[ROOT_STEPS].zero);
			ppt_s[0]   <= rpt_s[ROOT_STEPS];
		end
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_pitch
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) pv_s[k+1] <= 1'b0;
			else if (adv) pv_s[k+1] <= pv_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pitch_s[k+1] <= cordic_step(pitch_s[k], k);
				yawr_s[k+1]  <= yawr_s[k];
				ppt_s[k+1]   <= ppt_s[k];
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stage 9: image fractions u, v clamped to [0, 2^ANGLE_BITS]
	// ---------------------------------------------------------------------
	logic                    v_s9;
	logic [FR_W-1:0]         u_s9;
	logic [FR_W-1:0]         fv_s9;
	logic [PT_W-1:0]         pt_s9;
	logic signed [ANG_W-1:0] pitch_r;
	logic signed [ANG_W:0]   u_raw;
	logic signed [ANG_W+1:0] v_raw;
	logic [FR_W-1:0]         u_clp;
	logic [FR_W-1:0]         v_clp;

	always_comb begin
		pitch_r = angle_round(pitch_s[CORDIC_STEPS].a, pitch_s[CORDIC_STEPS].zero);
		u_raw   = (ANG_W + 1)'(yawr_s[CORDIC_STEPS]) + HALF_U;
		v_raw   = HALF_V - ((ANG_W + 2)'(pitch_r) <<< 1);
		if (u_raw[ANG_W]) u_clp = '0;
		else if (u_raw > FULL_U) u_clp = FR_W'(FULL_U);
		else u_clp = FR_W'(u_raw);
		if (v_raw[ANG_W+1]) v_clp = '0;
		else if (v_raw > FULL_V) v_clp = FR_W'(FULL_V);
		else v_clp = FR_W'(v_raw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (adv) v_s9 <= pv_s[CORDIC_STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s9  <= u_clp;
			fv_s9 <= v_clp;
			pt_s9 <= ppt_s[CORDIC_STEPS];
		end
	end

	// ---------------------------------------------------------------------
	// Stage 10: scale fractions by the image size
	// ---------------------------------------------------------------------
	logic            v_s10;
	logic [PM_W-1:0] cprod_s10;
	logic [PM_W-1:0] rprod_s10;
	logic [PT_W-1:0] pt_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s10 <= 1'b0;
		else if (adv) v_s10 <= v_s9;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cprod_s10 <= PM_W'(u_s9) * PM_W'(w_eff);
			rprod_s10 <= PM_W'(fv_s9) * PM_W'(h_eff);
			pt_s10    <= pt_s9;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 11: truncate, clamp to the last pixel, zero dropped points
	// ---------------------------------------------------------------------
	logic            v_s11;
	logic [11:0]     col_s11;
	logic [11:0]     row_s11;
	logic [PT_W-1:0] pt_s11;
	logic [13:0]     col_t;
	logic [13:0]     row_t;
	logic [12:0]     w_last;
	logic [12:0]     h_last;
	logic [11:0]     col_c;
	logic [11:0]     row_c;

	always_comb begin
		col_t  = cprod_s10[ANGLE_BITS +: 14];
		row_t  = rprod_s10[ANGLE_BITS +: 14];
		w_last = w_eff - 13'd1;
		h_last = h_eff - 13'd1;
		col_c  = (col_t > 14'(w_last)) ? w_last[11:0] : col_t[11:0];
		row_c  = (row_t > 14'(h_last)) ? h_last[11:0] : row_t[11:0];
		if (!pt_s10[PT_W-1]) begin
			col_c = '0;
			row_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s11 <= 1'b0;
		else if (adv) v_s11 <= v_s10;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s11 <= col_c;
			row_s11 <= row_c;
			pt_s11  <= pt_s10;
		end
	end

	// ---------------------------------------------------------------------
	// Output register with a one-entry skid buffer
	// ---------------------------------------------------------------------
	logic            out_v_q;
	logic [OB_W-1:0] out_d_q;
	logic [OB_W-1:0] skid_d_q;
	logic [OB_W-1:0] res_d;
	logic            pipe_in;
	logic            out_take;

	assign res_d    = {pt_s11[PT_W-1], pt_s11[PT_W-2],
		(OUT_W)'({pt_s11[3*CB-1:0], row_s11, col_s11})};
	assign pipe_in  = adv && v_s11;
	assign out_take = out_v_q && m_tready;

	// Track occupancy of the output register and the skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_take) begin
			if (skid_v_q) skid_v_q <= 1'b0;
			else out_v_q <= pipe_in;
		end else if (out_v_q) begin
			if (pipe_in) skid_v_q <= 1'b1;
		end else begin
			out_v_q <= pipe_in;
		end
	end

	// Move results into the output register or park them in the skid entry
	always_ff @(posedge clk) begin
		if (out_take) begin
			if (skid_v_q) out_d_q <= skid_d_q;
			else if (pipe_in) out_d_q <= res_d;
		end else if (out_v_q) begin
			if (pipe_in) skid_d_q <= res_d;
		end else if (pipe_in) begin
			out_d_q <= res_d;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q[OUT_W-1:0];
	assign m_tlast  = out_d_q[OUT_W];
	assign m_tuser  = out_d_q[OUT_W+1];

endmodule
